// ===== hw/rtl/trimmed_mean_sample_filter_assert.svh =====
// assertion macros for the trimmed mean sample filter checker
// relies on clk and rst_n being visible where a macro is used
`ifndef TRIMMED_MEAN_SAMPLE_FILTER_ASSERT_SVH
`define TRIMMED_MEAN_SAMPLE_FILTER_ASSERT_SVH

// implication checked on every edge outside reset
`define TMSF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define TMSF_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/tmsf_pkg.sv =====
// shared widths, defaults and types of the trimmed mean sample filter
// no dependencies
`default_nettype none

package tmsf_pkg;

    localparam int SAMPLE_W             = 16;
    localparam int SUM_W                = 23;  // 128 samples of 16 bits
    localparam int MAG_W                = 22;  // rounded magnitude of the trimmed sum
    localparam int RECIP_W              = MAG_W + 1;
    localparam int SAMPLE_COUNT_DEFAULT = 12;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

    // closing totals of one batch
    typedef struct packed {
        sum_t    sum;
        sample_t batch_min;
        sample_t batch_max;
    } batch_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tmsf_sample_if.sv =====
// valid/ready channel carrying one converter sample per transaction
// depends on tmsf_pkg
`default_nettype none

interface tmsf_sample_if;

    logic                 valid;
    logic                 ready;
    tmsf_pkg::sample_t    sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/tmsf_result_if.sv =====
// valid/ready channel carrying one filtered value per transaction
// depends on tmsf_pkg
`default_nettype none

interface tmsf_result_if;

    logic                 valid;
    logic                 ready;
    tmsf_pkg::sample_t    filtered_value;

    modport source (output valid, output filtered_value, input ready);
    modport sink   (input valid, input filtered_value, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/trimmed_mean_sample_filter.sv =====
// trimmed mean sample filter: batch accumulator feeding the rounding divider
// depends on tmsf_pkg, tmsf_sample_if, tmsf_result_if and tmsf_divider
//
// usage
//   samples : sink channel, one signed 16-bit converter sample per transaction
//   results : source channel, one signed 16-bit filtered value per batch
//   every SAMPLE_COUNT samples form a batch; its sum less one minimum and one
//   maximum is divided by SAMPLE_COUNT-2, rounding half away from zero
//   throughput: one sample per cycle unless a closing sample waits for the
//   divider; the accumulator update (one add and two compares) is the only
//   work done per sample
//   pipeline: the closing totals pass the batch register, trim and round,
//   reciprocal multiply and output register stages in that order
//   stall: a stalled receiver holds the result; samples keep flowing, and only
//   the sample closing a batch waits, when all four divider stages are full
//   reset: batch count cleared, divider pipeline emptied, no result pending
`default_nettype none

module trimmed_mean_sample_filter #(
    parameter int SAMPLE_COUNT = tmsf_pkg::SAMPLE_COUNT_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tmsf_sample_if.sink   samples,
    tmsf_result_if.source results
);

    localparam int CNT_W = $clog2(SAMPLE_COUNT);

    logic [CNT_W-1:0]  count_reg, count_next;
    tmsf_pkg::sum_t    sum_reg;
    tmsf_pkg::sample_t min_reg, max_reg;
    tmsf_pkg::batch_t  acc_next;
    logic              first, last, accept;
    logic              batch_valid, batch_ready;

    assign first  = (count_reg == '0);
    assign last   = (count_reg == CNT_W'(SAMPLE_COUNT - 1));
    assign accept = samples.valid && samples.ready;

    // mid-batch samples never wait; the closing one needs room in the divider
    assign samples.ready = !last || batch_ready;
    assign batch_valid   = samples.valid && last;

    // running totals including the sample on the port
    always_comb
    begin
        if (first)
        begin
            acc_next.sum       = tmsf_pkg::SUM_W'(samples.sample);
            acc_next.batch_min = samples.sample;
            acc_next.batch_max = samples.sample;
        end
        else
        begin
            acc_next.sum       = sum_reg + tmsf_pkg::SUM_W'(samples.sample);
            acc_next.batch_min = (samples.sample < min_reg) ? samples.sample : min_reg;
            acc_next.batch_max = (samples.sample > max_reg) ? samples.sample : max_reg;
        end
        count_next = last ? '0 : count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    // totals need no reset: the first sample of each batch loads them
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_reg <= acc_next.sum;
            min_reg <= acc_next.batch_min;
            max_reg <= acc_next.batch_max;
        end
    end

    // trim, round and divide, with the output register
    tmsf_divider #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_divider (
        .clk         (clk),
        .rst_n       (rst_n),
        .batch_valid (batch_valid),
        .batch_ready (batch_ready),
        .batch       (acc_next),
        .results     (results)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/tmsf_divider.sv =====
// elastic trim, round and divide pipeline: batch totals in, filtered value out
// depends on tmsf_pkg and tmsf_result_if
`default_nettype none

module tmsf_divider #(
    parameter int SAMPLE_COUNT = tmsf_pkg::SAMPLE_COUNT_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            batch_valid,
    output logic                 batch_ready,
    input  wire tmsf_pkg::batch_t batch,
    tmsf_result_if.source        results
);

    localparam int DIV   = SAMPLE_COUNT - 2;
    localparam int HALF  = DIV / 2;
    localparam int SHIFT = tmsf_pkg::MAG_W + $clog2(DIV);
    localparam int PROD_W = tmsf_pkg::MAG_W + tmsf_pkg::RECIP_W;
    // ceil(2^SHIFT / DIV): exact floor quotient for every MAG_W-bit magnitude
    localparam longint unsigned RECIP =
        ((longint'(1) << SHIFT) + longint'(DIV) - 1) / longint'(DIV);
    localparam logic [tmsf_pkg::RECIP_W-1:0] RECIP_V = tmsf_pkg::RECIP_W'(RECIP);

    logic                            v1_reg, v2_reg, v3_reg, vo_reg;
    logic                            en1, en2, en3, ldo;
    tmsf_pkg::batch_t                b1_reg;
    tmsf_pkg::sum_t                  trimmed;
    logic                            neg;
    logic [tmsf_pkg::SUM_W-1:0]      abs_val;
    logic [tmsf_pkg::MAG_W-1:0]      mag_reg, mag_next;
    logic                            neg2_reg, neg3_reg;
    logic [PROD_W-1:0]               prod_reg, prod_next;
    logic [tmsf_pkg::SAMPLE_W-1:0]   quot;
    tmsf_pkg::sample_t               out_reg, out_next;

    function automatic tmsf_pkg::sum_t batch_min_max_removed(input tmsf_pkg::batch_t b);
        return b.sum - tmsf_pkg::SUM_W'(b.batch_min) - tmsf_pkg::SUM_W'(b.batch_max);
    endfunction

    // stall chain, a stage loads when it is empty or its successor moves
    assign ldo         = !vo_reg || results.ready;
    assign en3         = !v3_reg || ldo;
    assign en2         = !v2_reg || en3;
    assign en1         = !v1_reg || en2;
    assign batch_ready = en1;

    always_comb
    begin
        trimmed  = batch_min_max_removed(b1_reg);
        neg      = trimmed[tmsf_pkg::SUM_W-1];
        abs_val  = neg ? tmsf_pkg::SUM_W'(-trimmed) : tmsf_pkg::SUM_W'(trimmed);
        mag_next = abs_val[tmsf_pkg::MAG_W-1:0] + tmsf_pkg::MAG_W'(HALF);
    end

    assign prod_next = PROD_W'(mag_reg) * PROD_W'(RECIP_V);
    assign quot      = prod_reg[SHIFT +: tmsf_pkg::SAMPLE_W];
    assign out_next  = $signed(neg3_reg ? (~quot + 1'b1) : quot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= batch_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (ldo)
            begin
                vo_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            b1_reg <= batch;
        end
        if (en2)
        begin
            mag_reg  <= mag_next;
            neg2_reg <= neg;
        end
        if (en3)
        begin
            prod_reg <= prod_next;
            neg3_reg <= neg2_reg;
        end
        if (ldo)
        begin
            out_reg <= out_next;
        end
    end

    assign results.valid          = vo_reg;
    assign results.filtered_value = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tmsf_checker.sv =====
// port-level checks of the trimmed mean sample filter, bound to the top level
// depends on tmsf_pkg, trimmed_mean_sample_filter_assert.svh and the top level
`default_nettype none

`include "trimmed_mean_sample_filter_assert.svh"

module tmsf_checker #(
    parameter int SAMPLE_COUNT = tmsf_pkg::SAMPLE_COUNT_DEFAULT
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [tmsf_pkg::SAMPLE_W-1:0] out_value
);

    localparam int CNT_W  = $clog2(SAMPLE_COUNT);
    localparam int PEND_W = 3;
    localparam logic [PEND_W-1:0] PEND_MAX = PEND_W'(4);

    logic [CNT_W-1:0]  cnt_reg;
    logic [PEND_W-1:0] pend_reg;
    logic              in_acc, out_acc, closing;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;
    assign closing = in_acc && (cnt_reg == CNT_W'(SAMPLE_COUNT - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pend_reg <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                cnt_reg <= closing ? '0 : cnt_reg + 1'b1;
            end
            pend_reg <= pend_reg + PEND_W'(closing) - PEND_W'(out_acc);
        end
    end

    `TMSF_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_value), "result changed while stalled")
    `TMSF_ASSERT(a_no_spurious, out_valid |-> pend_reg != '0, "result without a completed batch")
    `TMSF_ASSERT(a_ready_mid, !in_ready |-> cnt_reg == CNT_W'(SAMPLE_COUNT - 1), "sample refused mid-batch")
    `TMSF_ASSERT_NEVER(a_pend_cap, pend_reg > PEND_MAX, "more batches in flight than divider stages")

endmodule

bind trimmed_mean_sample_filter tmsf_checker #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
) u_tmsf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_value (results.filtered_value)
);

`default_nettype wire

// ===== tb/trimmed_mean_sample_filter_tb.sv =====
// self-checking testbench of the trimmed mean sample filter: directed and random batches
// depends on tmsf_pkg, tmsf_sample_if, tmsf_result_if and the filter rtl
`timescale 1ns / 1ps

module trimmed_mean_sample_filter_tb;

    localparam int BATCH_LEN   = tmsf_pkg::SAMPLE_COUNT_DEFAULT;
    localparam int TRIM_DIV    = BATCH_LEN - 2;
    localparam int IDLE_PCT    = 38;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 20;
    localparam int CYCLE_LIMIT = 100000;
    localparam int PRINT_LIMIT = 100;

    // flavours of a random batch
    typedef enum int
    {
        BATCH_UNIFORM,
        BATCH_LEVEL,
        BATCH_EXTREMES,
        BATCH_NEAR_ZERO
    } batch_kind_t;

    logic clk;
    logic rst_n;

    tmsf_sample_if sample_ch ();
    tmsf_result_if result_ch ();

    trimmed_mean_sample_filter #(
        .SAMPLE_COUNT (BATCH_LEN)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch)
    );

    // samples waiting for the driver, and filtered values still owed by the block
    tmsf_pkg::sample_t pending_samples[$];
    tmsf_pkg::sample_t expected_means[$];

    // own copy of the batch accumulator
    int acc_count;
    int acc_sum;
    int acc_min;
    int acc_max;

    int error_count;
    int accepted_count;
    int cycle_count;

    // steady: no idling on either side; hold_results: receiver held off
    logic steady;
    logic hold_results;

    // random batch generator state
    batch_kind_t       gen_kind;
    tmsf_pkg::sample_t gen_level;
    int                gen_index;

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // one line per mismatch, the first ones only, every one counted
    task automatic report_mismatch(input string what, input tmsf_pkg::sample_t got,
                                   input tmsf_pkg::sample_t want);
        if (error_count < PRINT_LIMIT)
        begin
            $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        end
        error_count++;
    endtask

    // fold one accepted sample into the batch; the closing sample yields the
    // rounded mean of the batch less one minimum and one maximum
    task automatic fold_sample(input tmsf_pkg::sample_t s);
        int trimmed;
        int half;
        int mean;
        if (acc_count == 0)
        begin
            acc_sum = s;
            acc_min = s;
            acc_max = s;
        end
        else
        begin
            acc_sum += s;
            if (s < acc_min)
                acc_min = s;
            if (s > acc_max)
                acc_max = s;
        end
        acc_count++;
        if (acc_count == BATCH_LEN)
        begin
            acc_count = 0;
            trimmed   = acc_sum - acc_min - acc_max;
            half      = TRIM_DIV / 2;
            // half away from zero, then truncation toward zero
            if (trimmed >= 0)
                mean = (trimmed + half) / TRIM_DIV;
            else
                mean = (trimmed - half) / TRIM_DIV;
            expected_means.push_back(tmsf_pkg::sample_t'(mean));
        end
    endtask

    // one random sample; the flavour of the batch is redrawn at each batch start
    function automatic tmsf_pkg::sample_t draw_sample();
        tmsf_pkg::sample_t s;
        int                pick;
        if (gen_index % BATCH_LEN == 0)
        begin
            pick = $urandom_range(0, 5);
            if (pick < 3)
                gen_kind = BATCH_UNIFORM;
            else if (pick == 3)
                gen_kind = BATCH_LEVEL;
            else if (pick == 4)
                gen_kind = BATCH_EXTREMES;
            else
                gen_kind = BATCH_NEAR_ZERO;
            case ($urandom_range(0, 3))
                0:       gen_level = 16'sh8000;
                1:       gen_level = 16'sh7FFF;
                default: gen_level = tmsf_pkg::sample_t'($urandom);
            endcase
        end
        gen_index++;
        case (gen_kind)
            BATCH_LEVEL:
                s = gen_level;
            BATCH_EXTREMES:
                case ($urandom_range(0, 3))
                    0:       s = 16'sh8000;
                    1:       s = 16'sh7FFF;
                    2:       s = tmsf_pkg::sample_t'(-32768 + int'($urandom_range(0, 3)));
                    default: s = tmsf_pkg::sample_t'(32767 - int'($urandom_range(0, 3)));
                endcase
            // small values, so that the trimmed sum often ends on a half
            BATCH_NEAR_ZERO:
                s = tmsf_pkg::sample_t'(int'($urandom_range(0, 40)) - 20);
            default:
                s = tmsf_pkg::sample_t'($urandom);
        endcase
        return s;
    endfunction

    // queue random samples; filled between edges so the driver sees them whole
    task automatic queue_random(input int n);
        @(negedge clk);
        for (int i = 0; i < n; i++)
            pending_samples.push_back(draw_sample());
    endtask

    // sender pause: every sample taken and every filtered value returned
    task automatic drain();
        while (pending_samples.size() != 0 || sample_ch.valid)
            @(posedge clk);
        while (expected_means.size() != 0)
            @(posedge clk);
    endtask

    // driver: offers queued samples, keeps an offered transaction until taken
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_ch.valid  <= 1'b0;
            sample_ch.sample <= '0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                fold_sample(sample_ch.sample);
                accepted_count++;
            end
            if (sample_ch.valid && !sample_ch.ready)
            begin
                // stalled: leave valid and the sample as they are
            end
            else if (pending_samples.size() != 0
                     && (steady || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                sample_ch.valid  <= 1'b1;
                sample_ch.sample <= pending_samples.pop_front();
            end
            else
            begin
                sample_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_means.size() == 0)
                    report_mismatch("unexpected result", result_ch.filtered_value, '0);
                else if (result_ch.filtered_value !== expected_means[0])
                    report_mismatch("filtered_value", result_ch.filtered_value,
                                    expected_means.pop_front());
                else
                    void'(expected_means.pop_front());
            end
            result_ch.ready <= !hold_results
                               && (steady || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[%0t] timeout, %0d filtered values outstanding",
                     $realtime, expected_means.size());
            $display("FAILURE");
            $finish;
        end
    end

    // long receiver hold-off while the sender keeps offering; the divider
    // pipeline fills and the sample closing a batch has to wait
    initial
    begin
        hold_results = 1'b0;
        while (accepted_count < 150)
            @(posedge clk);
        @(negedge clk);
        hold_results = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        @(negedge clk);
        hold_results = 1'b0;
    end

    // stimulus and end of run
    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        steady          = 1'b0;
        acc_count       = 0;
        acc_sum         = 0;
        acc_min         = 0;
        acc_max         = 0;
        error_count     = 0;
        accepted_count  = 0;
        cycle_count     = 0;
        gen_kind        = BATCH_UNIFORM;
        gen_level       = '0;
        gen_index       = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: both extremes twice, alternating bit patterns, then a
        // batch of equal minima where only one copy of each extreme goes
        @(negedge clk);
        pending_samples.push_back(16'sh7FFF);
        pending_samples.push_back(16'sh8000);
        pending_samples.push_back(16'sh7FFF);
        pending_samples.push_back(16'sh8000);
        pending_samples.push_back(16'sh5555);
        pending_samples.push_back(16'shAAAA);
        pending_samples.push_back(16'sh0000);
        pending_samples.push_back(16'shFFFF);
        pending_samples.push_back(16'sh0001);
        pending_samples.push_back(16'sh7FFE);
        pending_samples.push_back(16'sh8001);
        pending_samples.push_back(16'sh3039);
        for (int i = 0; i < BATCH_LEN; i++)
            pending_samples.push_back(16'sh8000);
        drain();

        // random with idling on both sides; the hold-off lands in here
        queue_random(500);
        drain();

        // back to back, no idling at all
        @(negedge clk);
        steady = 1'b1;
        queue_random(500);
        drain();
        @(negedge clk);
        steady = 1'b0;

        // random again; phases do not line up with batches
        queue_random(526);
        drain();

        repeat (SETTLE) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== trimmed_mean_sample_filter.f =====
+incdir+hw/rtl
hw/rtl/tmsf_pkg.sv
hw/rtl/tmsf_sample_if.sv
hw/rtl/tmsf_result_if.sv
hw/rtl/tmsf_divider.sv
hw/rtl/trimmed_mean_sample_filter.sv
hw/rtl/tmsf_checker.sv
tb/trimmed_mean_sample_filter_tb.sv
